/* rtl/skht_pkg.sv */
// ----------------------------------------------------------------------------
// skht_pkg
// Types and constants shared by the string key hash table modules.
// ----------------------------------------------------------------------------
package skht_pkg;

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_WRITE  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // status codes
  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_MISSING  = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  // entry count; the start slot reduction folds hash bytes, so this is 2**8 - 1
  localparam int unsigned TableEntries = 255;

  typedef struct packed {
    logic [1:0]         operation;
    logic [63:0]        key_bytes;
    logic [3:0]         key_length;
    logic signed [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         slot;
    logic signed [31:0] entry_value;
    logic [7:0]         entries_used;
  } rsp_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;       // capture request, start hash
    logic hash_step;  // one key byte into the hash
    logic hash_final; // final avalanche
    logic mod_step;   // reduce the hash to the start slot
    logic rd;         // issue memory read at probe slot
    logic advance;    // move to next slot
    logic wr_new;     // write a new entry
    logic wr_val;     // overwrite value of found entry
    logic clr_step;   // clear one occupancy bit
    logic clr_start;  // start clear sweep
    logic emit;       // present result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_clear;
    logic hash_done;
    logic mod_done;
    logic occupied;
    logic matched;
    logic wrapped;
    logic load_full;
    logic is_lookup;
    logic is_write;
    logic clr_done;
  } sts_t;

endpackage

/* rtl/string_key_hash_table_linear_probe_core.sv */
// ----------------------------------------------------------------------------
// string_key_hash_table_linear_probe_core
// Open addressing table of short string keys with linear probing.
// ----------------------------------------------------------------------------
// A request is taken when start_i is high and busy_o low; its single result
// shows on rsp_o for one cycle with valid_o and cannot be held off, since the
// receiver cannot stall. A request keeps busy_o high while it runs through
// its steps in order: the hash takes in the key a byte per step and ends,
// then come the final mixing, the fold of the hash to the start slot, the
// read of the entry memory, the check of it and the showing of the result;
// each extra probed slot adds a read and a check. A key cut short by a zero
// byte adds a hash step, and a write to an existing entry adds a write step.
// The result beat lies in the last busy cycle and the next request can be
// taken as soon as busy_o is low. Clear sweeps the occupancy bits one slot
// a cycle.
module string_key_hash_table_linear_probe_core #(
  parameter int unsigned MaxKeyBytes  = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  skht_pkg::req_t req_i,
  output logic           busy_o,
  output logic           valid_o,
  output skht_pkg::rsp_t rsp_o
);

  skht_pkg::cmd_t cmd;
  skht_pkg::sts_t sts;

  skht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  skht_dp #(
    .MaxKeyBytes (MaxKeyBytes)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

endmodule

/* rtl/skht_ctrl.sv */
// ----------------------------------------------------------------------------
// skht_ctrl
// Sequencer for hashing, probing, writing and clearing.
// ----------------------------------------------------------------------------
module skht_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  skht_pkg::sts_t sts_i,
  output skht_pkg::cmd_t cmd_o
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_HASH  = 9'b000000010,
    S_FINAL = 9'b000000100,
    S_MOD   = 9'b000001000,
    S_READ  = 9'b000010000,
    S_CHECK = 9'b000100000,
    S_WRITE = 9'b001000000,
    S_CLEAR = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (sts_i.is_clear) begin
          cmd_o.clr_start = 1'b1;
          state_d         = S_CLEAR;
        end else if (sts_i.hash_done) begin
          state_d = S_FINAL;
        end else begin
          cmd_o.hash_step = 1'b1;
        end
      end
      S_FINAL: begin
        cmd_o.hash_final = 1'b1;
        state_d          = S_MOD;
      end
      S_MOD: begin
        if (sts_i.mod_done) begin
          cmd_o.rd = 1'b1;
          state_d  = S_CHECK;
        end else begin
          cmd_o.mod_step = 1'b1;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.occupied && sts_i.matched) begin
          if (sts_i.is_write) begin
            cmd_o.wr_val = 1'b1;
            state_d      = S_WRITE;
          end else begin
            cmd_o.emit = 1'b1;
            state_d    = S_DONE;
          end
        end else if (!sts_i.occupied) begin
          if (!sts_i.is_lookup && !sts_i.load_full) begin
            cmd_o.wr_new = 1'b1;
          end
          cmd_o.emit = 1'b1;
          state_d    = S_DONE;
        end else if (sts_i.wrapped) begin
          cmd_o.emit = 1'b1;
          state_d    = S_DONE;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = S_READ;
        end
      end
      S_WRITE: begin
        cmd_o.emit = 1'b1;
        state_d    = S_DONE;
      end
      S_CLEAR: begin
        if (sts_i.clr_done) begin
          cmd_o.emit = 1'b1;
          state_d    = S_DONE;
        end else begin
          cmd_o.clr_step = 1'b1;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

`ifndef ASSERT_OFF
  // a result is only presented once a request has been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> busy_o)
    else $error("result without request");
  // new entry and value update never coincide
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.wr_new && cmd_o.wr_val))
    else $error("double write");
  // every result returns to idle by way of the done state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> ##1 !busy_o)
    else $error("no return to idle");
`endif

endmodule

/* rtl/skht_dp.sv */
// ----------------------------------------------------------------------------
// skht_dp
// Hash unit, slot reduction, entry memory and result register.
// ----------------------------------------------------------------------------
module skht_dp #(
  parameter int unsigned MaxKeyBytes  = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  skht_pkg::req_t req_i,
  input  skht_pkg::cmd_t cmd_i,
  output skht_pkg::sts_t sts_o,
  output logic           valid_o,
  output skht_pkg::rsp_t rsp_o
);

  localparam int unsigned TableEntries = skht_pkg::TableEntries;
  localparam int unsigned SlotW  = $clog2(TableEntries);
  localparam int unsigned CountW = $clog2(TableEntries + 1);
  localparam int unsigned LenW   = 4;
  localparam logic [LenW-1:0] MaxLen = LenW'(MaxKeyBytes);
  localparam logic [CountW+1:0] LoadLimit = (CountW+2)'(2 * TableEntries);
  localparam logic [SlotW-1:0] LastSlot = SlotW'(TableEntries - 1);
  localparam logic [8:0] Modulus = 9'(TableEntries);

  typedef struct packed {
    logic [31:0]          hash;
    logic [63:0]          key;
    logic [LenW-1:0]      len;
    logic signed [31:0]   value;
  } entry_t;

  // request registers
  logic [1:0]         op_q;
  logic [63:0]        raw_q, key_q;
  logic [LenW-1:0]    given_q, idx_q, len_q;
  logic               stop_q;
  logic signed [31:0] wval_q;
  logic [31:0]        hash_q;
  logic               mod_done_q;
  logic [SlotW-1:0]   slot_q, start_q, clr_q;
  logic               clr_done_q;
  logic [CountW-1:0]  count_q;
  logic [TableEntries-1:0] occ_q;
  entry_t             mem [TableEntries];
  entry_t             rd_q;
  logic               occ_rd_q;
  logic               wrapped_q;
  logic               key_match;
  skht_pkg::rsp_t     rsp_d;

  // current key byte; it is sign extended into the hash
  logic [7:0]  byte_w;
  logic [31:0] h1, h2, h3, f1, f2, f3;
  logic [9:0]  fold1;
  logic [8:0]  fold2;
  logic [SlotW-1:0] start_w;
  assign byte_w = raw_q[{idx_q[2:0], 3'b000} +: 8];
  assign h1 = hash_q + {{24{byte_w[7]}}, byte_w};
  assign h2 = h1 + (h1 << 10);
  assign h3 = h2 ^ (h2 >> 6);
  assign f1 = hash_q + (hash_q << 3);
  assign f2 = f1 ^ (f1 >> 11);
  assign f3 = f2 + (f2 << 15);
  // remainder by 2**8 - 1: sum the hash bytes, fold the carries back, one subtract
  assign fold1 = {2'b00, hash_q[7:0]} + {2'b00, hash_q[15:8]} +
                 {2'b00, hash_q[23:16]} + {2'b00, hash_q[31:24]};
  assign fold2 = {1'b0, fold1[7:0]} + {7'b0000000, fold1[9:8]};
  assign start_w = (fold2 >= Modulus) ? SlotW'(fold2 - Modulus) : SlotW'(fold2);

  always_ff @(posedge clk_i) begin
    // request capture
    if (cmd_i.load) begin
      op_q    <= req_i.operation;
      raw_q   <= req_i.key_bytes;
      given_q <= (req_i.key_length > MaxLen) ? MaxLen : req_i.key_length;
      wval_q  <= req_i.write_value;
      idx_q   <= '0;
      len_q   <= '0;
      stop_q  <= 1'b0;
      key_q   <= '0;
      hash_q  <= '0;
    end
    // one byte per step
    if (cmd_i.hash_step) begin
      if (byte_w == 8'd0) begin
        stop_q <= 1'b1;
      end else begin
        hash_q <= h3;
        key_q[{idx_q[2:0], 3'b000} +: 8] <= byte_w;
        len_q  <= idx_q + 1'b1;
        idx_q  <= idx_q + 1'b1;
      end
    end
    if (cmd_i.hash_final) begin
      hash_q     <= f3;
      mod_done_q <= 1'b0;
    end
    if (cmd_i.mod_step) begin
      mod_done_q <= 1'b1;
    end
    if (cmd_i.rd) begin
      rd_q <= mem[slot_q];
    end
    if (cmd_i.wr_new) begin
      mem[slot_q] <= '{hash: hash_q, key: key_q, len: len_q,
                       value: (op_q == skht_pkg::OP_WRITE) ? wval_q : 32'sd0};
    end else if (cmd_i.wr_val) begin
      mem[slot_q] <= '{hash: rd_q.hash, key: rd_q.key, len: rd_q.len, value: wval_q};
    end
  end

  // slot pointer, occupancy and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q      <= '0;
      count_q    <= '0;
      slot_q     <= '0;
      start_q    <= '0;
      clr_q      <= '0;
      clr_done_q <= 1'b0;
      occ_rd_q   <= 1'b0;
      wrapped_q  <= 1'b0;
      valid_o    <= 1'b0;
    end else begin
      valid_o <= cmd_i.emit;
      if (cmd_i.mod_step) begin
        slot_q  <= start_w;
        start_q <= start_w;
      end
      if (cmd_i.rd) begin
        occ_rd_q <= occ_q[slot_q];
      end
      if (cmd_i.hash_final) begin
        wrapped_q <= 1'b0;
      end
      if (cmd_i.advance) begin
        slot_q    <= (slot_q == LastSlot) ? '0 : slot_q + 1'b1;
        wrapped_q <= (((slot_q == LastSlot) ? '0 : slot_q + 1'b1) == start_q);
      end
      if (cmd_i.wr_new) begin
        occ_q[slot_q] <= 1'b1;
        count_q       <= count_q + 1'b1;
      end
      if (cmd_i.clr_start) begin
        clr_q      <= '0;
        clr_done_q <= 1'b0;
        count_q    <= '0;
      end
      if (cmd_i.clr_step) begin
        occ_q[clr_q] <= 1'b0;
        clr_q        <= (clr_q == LastSlot) ? '0 : clr_q + 1'b1;
        if (clr_q == LastSlot) begin
          clr_done_q <= 1'b1;
        end
      end
    end
  end

  assign key_match = (rd_q.hash == hash_q) && (rd_q.len == len_q) && (rd_q.key == key_q);

  always_comb begin
    sts_o           = '0;
    sts_o.is_clear  = (op_q == skht_pkg::OP_CLEAR);
    sts_o.hash_done = stop_q || (idx_q >= given_q);
    sts_o.mod_done  = mod_done_q;
    sts_o.occupied  = occ_rd_q;
    sts_o.matched   = key_match;
    sts_o.wrapped   = wrapped_q || (((slot_q == LastSlot) ? '0 : slot_q + 1'b1) == start_q);
    sts_o.load_full = ((CountW+2)'(count_q) * (CountW+2)'(3)) > LoadLimit;
    sts_o.is_lookup = (op_q == skht_pkg::OP_LOOKUP);
    sts_o.is_write  = (op_q == skht_pkg::OP_WRITE);
    sts_o.clr_done  = clr_done_q;
  end

  // result selection
  always_comb begin
    rsp_d              = '0;
    rsp_d.entries_used = 8'(count_q);
    rsp_d.slot         = 8'(slot_q);
    if (sts_o.is_clear) begin
      rsp_d.status       = skht_pkg::ST_CLEARED;
      rsp_d.slot         = '0;
      rsp_d.entries_used = '0;
    end else if (occ_rd_q && key_match) begin
      rsp_d.status      = skht_pkg::ST_FOUND;
      rsp_d.entry_value = sts_o.is_write ? wval_q : rd_q.value;
    end else if (!occ_rd_q) begin
      if (sts_o.is_lookup) begin
        rsp_d.status = skht_pkg::ST_MISSING;
      end else if (sts_o.load_full) begin
        rsp_d.status = skht_pkg::ST_FULL;
      end else begin
        rsp_d.status       = skht_pkg::ST_INSERTED;
        rsp_d.entries_used = 8'(count_q + 1'b1);
        rsp_d.entry_value  = sts_o.is_write ? wval_q : 32'sd0;
      end
    end else begin
      rsp_d.slot   = 8'(start_q);
      rsp_d.status = sts_o.is_lookup ? skht_pkg::ST_MISSING : skht_pkg::ST_FULL;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_o <= rsp_d;
    end
  end

`ifndef ASSERT_OFF
  // entry count never passes the table size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(TableEntries))
    else $error("count overflow");
  // a new entry only goes to a free slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_new |-> !occ_q[slot_q])
    else $error("overwrite of used slot");
  // a value update only goes to a used slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_val |-> occ_q[slot_q])
    else $error("update of free slot");
`endif

endmodule

/* sim/tb_string_key_hash_table_linear_probe_core.sv */
// ----------------------------------------------------------------------------
// tb_string_key_hash_table_linear_probe_core
// Self-checking bench for the string key hash table: requests are driven with
// random gaps, every accepted request is run through a predictor of the table
// and each result beat is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_string_key_hash_table_linear_probe_core;

  localparam int unsigned Entries  = skht_pkg::TableEntries;
  localparam int unsigned MaxBytes = 8;
  localparam int unsigned CycleCap = 10000000;

  // mirror of the table and the queue of predicted result beats
  class table_scoreboard;
    bit             used_q[Entries];
    logic [31:0]    hash_q[Entries];
    logic [63:0]    key_q[Entries];
    logic [3:0]     len_q[Entries];
    logic [31:0]    val_q[Entries];
    int unsigned    count;
    skht_pkg::rsp_t pending[$];
    int unsigned    errors;

    function logic [31:0] oaat(logic [63:0] key, int unsigned len);
      logic [31:0] h;
      logic [31:0] b;
      h = 0;
      for (int i = 0; i < len; i++) begin
        b = {{24{key[8*i+7]}}, key[8*i +: 8]};
        h = h + b;
        h = h + (h << 10);
        h = h ^ (h >> 6);
      end
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      return h;
    endfunction

    // work out the result of one accepted request
    function void note_request(skht_pkg::req_t r);
      skht_pkg::rsp_t e;
      logic [63:0]    key;
      logic [31:0]    h;
      int unsigned    given, len, start, s, steps;
      bit             ended, found;
      key = 0;
      len = 0;
      ended = 0;
      found = 0;
      e = '0;
      if (r.operation == skht_pkg::OP_CLEAR) begin
        for (int i = 0; i < Entries; i++) used_q[i] = 0;
        count = 0;
        e.status = skht_pkg::ST_CLEARED;
        pending.push_back(e);
        return;
      end
      given = (r.key_length > MaxBytes) ? MaxBytes : r.key_length;
      for (int i = 0; i < given; i++) begin
        if (r.key_bytes[8*i +: 8] == 8'h00) break;
        key[8*i +: 8] = r.key_bytes[8*i +: 8];
        len = i + 1;
      end
      h = oaat(key, len);
      start = h % Entries;
      s = start;
      for (steps = 0; steps < Entries; steps++) begin
        if (!used_q[s]) begin
          ended = 1;
          break;
        end
        if (hash_q[s] == h && len_q[s] == len && key_q[s] == key) begin
          found = 1;
          break;
        end
        s = (s + 1) % Entries;
      end
      e.status = (r.operation == skht_pkg::OP_LOOKUP) ? skht_pkg::ST_MISSING
                                                      : skht_pkg::ST_FULL;
      if (found) begin
        if (r.operation == skht_pkg::OP_WRITE) val_q[s] = r.write_value;
        e.status = skht_pkg::ST_FOUND;
        e.entry_value = val_q[s];
      end else if (ended && r.operation != skht_pkg::OP_LOOKUP) begin
        if (3 * count <= 2 * Entries) begin
          used_q[s] = 1;
          hash_q[s] = h;
          key_q[s] = key;
          len_q[s] = len;
          val_q[s] = (r.operation == skht_pkg::OP_WRITE) ? r.write_value : 0;
          count++;
          e.status = skht_pkg::ST_INSERTED;
          e.entry_value = val_q[s];
        end
      end else if (!ended) begin
        s = start;
      end
      e.slot = s[7:0];
      e.entries_used = count[7:0];
      pending.push_back(e);
    endfunction

    function void check_result(skht_pkg::rsp_t a);
      skht_pkg::rsp_t e;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %p", a);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, a.status);
        errors++;
      end
      if (a.slot !== e.slot) begin
        $error("slot: expected %0d, actual %0d", e.slot, a.slot);
        errors++;
      end
      if (a.entry_value !== e.entry_value) begin
        $error("entry_value: expected %0d, actual %0d", e.entry_value, a.entry_value);
        errors++;
      end
      if (a.entries_used !== e.entries_used) begin
        $error("entries_used: expected %0d, actual %0d", e.entries_used, a.entries_used);
        errors++;
      end
    endfunction
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           start_i;
  skht_pkg::req_t req_i;
  logic           busy_o;
  logic           valid_o;
  skht_pkg::rsp_t rsp_o;

  table_scoreboard board;
  int unsigned     cycles = 0;
  bit              calm;
  logic [63:0]     key_pool[16];
  logic [3:0]      len_pool[16];

  string_key_hash_table_linear_probe_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // result monitor and run time guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && valid_o) board.check_result(rsp_o);
    if (cycles > CycleCap) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one request beat, with an optional idle burst ahead of it
  task automatic send(logic [1:0] op, logic [63:0] kb, logic [3:0] kl, logic [31:0] wv);
    int unsigned gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i <= '{operation: op, key_bytes: kb, key_length: kl, write_value: wv};
    do @(posedge clk_i); while (busy_o !== 1'b0);
    board.note_request(req_i);
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom(), $urandom()};
  endfunction

  initial begin
    int unsigned pick;
    logic [63:0] kb;
    logic [3:0]  kl;
    logic [1:0]  op;
    board = new();
    calm = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty key, zero byte cut, long length, sign bytes, all operations
    send(skht_pkg::OP_LOOKUP, 64'h0, 4'd0, 32'd0);
    send(skht_pkg::OP_INSERT, 64'h0, 4'd0, 32'd0);
    send(skht_pkg::OP_INSERT, 64'h0, 4'd0, 32'd0);
    send(skht_pkg::OP_WRITE,  64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 32'h7FFF_FFFF);
    send(skht_pkg::OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 32'd0);
    send(skht_pkg::OP_WRITE,  64'h1111_2222_0041_8061, 4'd8, 32'h8000_0000);
    send(skht_pkg::OP_LOOKUP, 64'h5555_5555_0000_8061, 4'd9, 32'd0);
    send(skht_pkg::OP_LOOKUP, 64'h0000_0000_0000_8061, 4'd1, 32'd0);
    send(skht_pkg::OP_WRITE,  64'h0000_0000_0000_0080, 4'd1, 32'hFFFF_FFFF);
    send(skht_pkg::OP_INSERT, 64'h0000_0000_0000_0080, 4'd1, 32'd5);
    send(skht_pkg::OP_WRITE,  64'h0102_0304_0506_0708, 4'd7, 32'd0);
    send(skht_pkg::OP_CLEAR,  64'h0, 4'd0, 32'd0);
    send(skht_pkg::OP_LOOKUP, 64'h0000_0000_0000_0080, 4'd1, 32'd0);
    // fill past the load rule, then probe a crowded table
    for (int i = 0; i < 200; i++)
      send(i % 2 ? skht_pkg::OP_WRITE : skht_pkg::OP_INSERT, rand_key(),
           4'($urandom_range(1, 8)), $urandom());
    for (int i = 0; i < 40; i++)
      send(skht_pkg::OP_LOOKUP, rand_key(), 4'($urandom_range(0, 15)), 0);
    send(skht_pkg::OP_CLEAR, 64'h0, 4'd0, 32'd0);

    // random: mostly a small pool of keys so that hits are common
    for (int i = 0; i < 16; i++) begin
      key_pool[i] = rand_key();
      len_pool[i] = 4'($urandom_range(0, 9));
    end
    for (int n = 0; n < 2000; n++) begin
      if (n == 1700) calm = 1;
      pick = $urandom_range(0, 99);
      if (pick < 2) op = skht_pkg::OP_CLEAR;
      else op = 2'($urandom_range(0, 2));
      if (pick < 70) begin
        kb = key_pool[pick % 16];
        kl = len_pool[pick % 16];
      end else begin
        kb = rand_key();
        kl = 4'($urandom_range(0, 15));
      end
      send(op, kb, kl, $urandom());
    end
    start_i <= 1'b0;

    // drain
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/skht_pkg.sv
rtl/skht_ctrl.sv
rtl/skht_dp.sv
rtl/string_key_hash_table_linear_probe_core.sv
sim/tb_string_key_hash_table_linear_probe_core.sv
